// ----- hw/rtl/trimmed_moving_average_filter_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the trimmed moving average filter
// Shared concurrent assertion forms, clocked on a rising edge, reset low.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MOVING_AVERAGE_FILTER_TOP_MACROS_SVH
`define TRIMMED_MOVING_AVERAGE_FILTER_TOP_MACROS_SVH

// Same-cycle implication
`define TMAF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmaf assertion failed");

// Next-cycle implication
`define TMAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmaf assertion failed");

// Delayed implication
`define TMAF_ASSERT_TWO(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("tmaf assertion failed");

`endif

// ----- hw/rtl/tmaf_pkg.sv -----
// ----------------------------------------------------------------------------
// tmaf_pkg
// Types and constants shared by the trimmed moving average filter.
// ----------------------------------------------------------------------------
package tmaf_pkg;

  // Window depth and sample format
  localparam int WINDOW   = 10;
  localparam int SAMPLE_W = 8;

  // Window sum width: enough for WINDOW full-scale samples
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  // Trimmed sum width, one guard bit
  localparam int TRIM_W = SUM_W + 1;

  // Divide by eight, truncated toward zero
  localparam int DIV_SHIFT = 3;
  localparam int DIV_BIAS  = (1 << DIV_SHIFT) - 1;

  // Output saturation limits
  localparam int OUT_MAX = 127;
  localparam int OUT_MIN = -128;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [WINDOW-1:0]       window_t;

endpackage

// ----- hw/rtl/tmaf_sample_if.sv -----
// ----------------------------------------------------------------------------
// tmaf_sample_if
// Valid/ready channel carrying one signed sample word.
// ----------------------------------------------------------------------------
interface tmaf_sample_if;

  logic                valid;
  logic                ready;
  logic signed [7:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

// ----- hw/rtl/tmaf_filtered_if.sv -----
// ----------------------------------------------------------------------------
// tmaf_filtered_if
// Valid/ready channel carrying one signed filtered word.
// ----------------------------------------------------------------------------
interface tmaf_filtered_if;

  logic                valid;
  logic                ready;
  logic signed [7:0]   filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);

endinterface

// ----- hw/rtl/trimmed_moving_average_filter_top.sv -----
// ----------------------------------------------------------------------------
// trimmed_moving_average_filter_top
// Ten-tap trimmed moving average over signed 8-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i   sink channel, one signed 8-bit sample word per handshake.
//   filtered_o source channel, one signed 8-bit result word per sample.
//   Each accepted sample enters the window shift line; the result is the
//   window sum less one largest and one smallest tap, divided by eight and
//   truncated toward zero.
// Path: the accepting edge loads the sample into the shift line; the output
//   register is loaded from the window when the output stage advances after
//   that, and the result word is then shown on filtered_o for taking.
// Throughput: one sample per cycle unless filtered_o stalls, set by the single-pass reduction tree
//   between the window register and the output register.
// Reset: rst_ni low clears the window to zero and empties the pipeline.
// Stall: while filtered_o is held (valid without ready) the output word
//   stays put; one more sample may still be taken into the window stage,
//   after which sample_i.ready drops until the output is taken.
// ----------------------------------------------------------------------------
module trimmed_moving_average_filter_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  tmaf_sample_if.sink     sample_i,
  tmaf_filtered_if.source filtered_o
);
  import tmaf_pkg::*;

  logic    in_accept;
  logic    advance;
  logic    s1_valid_q;
  logic    out_valid_q;
  sample_t filtered_q;
  window_t window;
  sample_t result;

  // handshake: output stage moves when empty or taken
  assign advance        = !out_valid_q || filtered_o.ready;
  assign sample_i.ready = !s1_valid_q || advance;
  assign in_accept      = sample_i.valid && sample_i.ready;

  tmaf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (in_accept),
    .sample_i (sample_i.sample),
    .window_o (window)
  );

  tmaf_reduce u_reduce (
    .window_i   (window),
    .filtered_o (result)
  );

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_i.ready) begin
        s1_valid_q <= in_accept;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      filtered_q <= result;
    end
  end

  assign filtered_o.valid    = out_valid_q;
  assign filtered_o.filtered = filtered_q;

endmodule

// ----- hw/rtl/tmaf_window.sv -----
// ----------------------------------------------------------------------------
// tmaf_window
// Sample shift line: newest sample at tap 0, oldest drops out; zero at reset.
// ----------------------------------------------------------------------------
module tmaf_window (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  tmaf_pkg::sample_t sample_i,
  output tmaf_pkg::window_t window_o
);
  import tmaf_pkg::*;

  window_t window_q;
  window_t window_d;

  // shift one tap toward the old end, new sample at tap 0
  always_comb begin
    window_d = window_q;
    if (shift_i) begin
      for (int i = WINDOW - 1; i > 0; i--) begin
        window_d[i] = window_q[i-1];
      end
      window_d[0] = sample_i;
    end
  end

  // window contents are state: reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else begin
      window_q <= window_d;
    end
  end

  assign window_o = window_q;

endmodule

// ----- hw/rtl/tmaf_reduce.sv -----
// ----------------------------------------------------------------------------
// tmaf_reduce
// Sum, max and min over the window by a balanced tree, trim, divide by 8 and saturate.
// ----------------------------------------------------------------------------
module tmaf_reduce (
  input  tmaf_pkg::window_t window_i,
  output tmaf_pkg::sample_t filtered_o
);
  import tmaf_pkg::*;

  localparam int LEVELS = $clog2(WINDOW);
  localparam int LEAVES = 1 << LEVELS;

  sample_t                  mx [LEVELS+1][LEAVES];
  sample_t                  mn [LEVELS+1][LEAVES];
  logic signed [SUM_W-1:0]  sm [LEVELS+1][LEAVES];

  logic signed [TRIM_W-1:0] trim;
  logic signed [TRIM_W-1:0] biased;
  logic signed [TRIM_W-1:0] quot;

  // reduction tree; pad leaves repeat tap 0 for max/min and add zero
  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int i = 0; i < LEAVES; i++) begin
        mx[l][i] = window_i[0];
        mn[l][i] = window_i[0];
        sm[l][i] = '0;
      end
    end
    for (int i = 0; i < WINDOW; i++) begin
      mx[0][i] = window_i[i];
      mn[0][i] = window_i[i];
      sm[0][i] = SUM_W'(window_i[i]);
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
        mx[l+1][i] = (mx[l][2*i+1] > mx[l][2*i]) ? mx[l][2*i+1] : mx[l][2*i];
        mn[l+1][i] = (mn[l][2*i+1] < mn[l][2*i]) ? mn[l][2*i+1] : mn[l][2*i];
        sm[l+1][i] = sm[l][2*i] + sm[l][2*i+1];
      end
    end
  end

  // drop one max and one min, divide toward zero, saturate
  always_comb begin
    trim   = TRIM_W'(sm[LEVELS][0]) - TRIM_W'(mx[LEVELS][0]) - TRIM_W'(mn[LEVELS][0]);
    biased = trim[TRIM_W-1] ? (trim + TRIM_W'(DIV_BIAS)) : trim;
    quot   = biased >>> DIV_SHIFT;
    if (quot > TRIM_W'(OUT_MAX)) begin
      filtered_o = SAMPLE_W'(OUT_MAX);
    end else if (quot < TRIM_W'(OUT_MIN)) begin
      filtered_o = SAMPLE_W'(OUT_MIN);
    end else begin
      filtered_o = quot[SAMPLE_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/tmaf_checker.sv -----
// ----------------------------------------------------------------------------
// tmaf_checker
// Port-level checks for the trimmed moving average filter, bound to the top.
// ----------------------------------------------------------------------------
`include "trimmed_moving_average_filter_top_macros.svh"

module tmaf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_filtered_i
);

  // a held output word keeps its value
  `TMAF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_filtered_i))

  // an empty output stage never back-pressures the input
  `TMAF_ASSERT_SAME(a_empty_ready, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // an accepted sample has a result word on show once it has passed the shift line and output register
  `TMAF_ASSERT_TWO(a_latency, clk_i, rst_ni, in_valid_i && in_ready_i, out_valid_i)

endmodule

bind trimmed_moving_average_filter_top tmaf_checker u_tmaf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .out_valid_i    (filtered_o.valid),
  .out_ready_i    (filtered_o.ready),
  .out_filtered_i (filtered_o.filtered)
);
